>>> hdl/stereo_line_pair_check_unit_assert.svh
// Assertion macros for the stereo line-pair check unit.
// No dependencies; included by the top level only.
`ifndef STEREO_LINE_PAIR_CHECK_UNIT_ASSERT_SVH
`define STEREO_LINE_PAIR_CHECK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SLPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slpc assertion failed");
`define SLPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slpc assertion failed");
`else
`define SLPC_ASSERT_SAME(lbl, ante, cons)
`define SLPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/slpc_pkg.sv
// Shared types and constants of the stereo line-pair check unit.
// No dependencies.
package slpc_pkg;
    localparam int FRAC_BITS  = 4;
    localparam int COORD_W    = 14;
    localparam int DISP_W     = 16;
    localparam int RATIO_W    = 9;
    localparam int DIV_W      = 30;   // dividend and quotient width
    localparam int DIV_STAGES = DIV_W;

    localparam logic [1:0] CFG_MIN_RATIO = 2'd0;
    localparam logic [1:0] CFG_HORIZ_LIM = 2'd1;
    localparam logic [1:0] CFG_MIN_DISP  = 2'd2;
    localparam logic [1:0] CFG_OVL_LIM   = 2'd3;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 9'd256;

    typedef struct packed {
        logic [COORD_W-1:0] left_start_x;
        logic [COORD_W-1:0] left_start_y;
        logic [COORD_W-1:0] left_end_x;
        logic [COORD_W-1:0] left_end_y;
        logic [COORD_W-1:0] right_start_x;
        logic [COORD_W-1:0] right_start_y;
        logic [COORD_W-1:0] right_end_x;
        logic [COORD_W-1:0] right_end_y;
    } t_pair_in;

    typedef struct packed {
        logic                      accept;
        logic signed [DISP_W-1:0]  start_disparity;
        logic signed [DISP_W-1:0]  end_disparity;
        logic [RATIO_W-1:0]        overlap_ratio;
    } t_result;

    // travels beside the dividers
    typedef struct packed {
        logic               neg_s;
        logic               neg_e;
        logic               zero;
        logic               tall;
        logic               len_ok;
        logic [COORD_W-1:0] lsx;
        logic [COORD_W-1:0] lex;
    } t_side;
endpackage

>>> hdl/slpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on slpc_pkg.
module slpc_div
    import slpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [COORD_W-1:0] i_divisor,
    output logic               o_valid,
    output logic [DIV_W-1:0]   o_quotient
);
    logic               r_v   [DIV_STAGES];
    logic [DIV_W-1:0]   r_dq  [DIV_STAGES];
    logic [COORD_W-1:0] r_rem [DIV_STAGES];
    logic [COORD_W-1:0] r_d   [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic               v_in;
            logic [DIV_W-1:0]   dq_in;
            logic [COORD_W-1:0] rem_in;
            logic [COORD_W-1:0] d_in;
            logic [COORD_W:0]   trial;
            logic [COORD_W:0]   diff;
            logic               ge;
            if (k == 0) begin : g_first
                assign v_in   = i_valid;
                assign dq_in  = i_dividend;
                assign rem_in = '0;
                assign d_in   = i_divisor;
            end else begin : g_next
                assign v_in   = r_v[k-1];
                assign dq_in  = r_dq[k-1];
                assign rem_in = r_rem[k-1];
                assign d_in   = r_d[k-1];
            end
            assign trial = {rem_in, dq_in[DIV_W-1]};
            assign diff  = trial - {1'b0, d_in};
            assign ge    = trial >= {1'b0, d_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= v_in;
                end
                r_dq[k]  <= {dq_in[DIV_W-2:0], ge};
                r_rem[k] <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                r_d[k]   <= d_in;
            end
        end
    endgenerate

    assign o_valid    = r_v[DIV_STAGES-1];
    assign o_quotient = r_dq[DIV_STAGES-1];
endmodule

>>> hdl/stereo_line_pair_check_unit.sv
// Top level of the stereo line-pair check unit.
// Depends on slpc_pkg, slpc_div and stereo_line_pair_check_unit_assert.svh.
//
//  channel | signals                          | timing
//  --------+----------------------------------+--------------------------------
//  pair in | start, busy, i_pair              | word taken when start & !busy
//  result  | o_strobe, o_result               | one cycle, no hold-off
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data  | written on any edge with we high
//
// One pair per clock; busy is always low. A result leaves after its pair has
// passed four front stages (capture, differences and overlap, products,
// rounding prep), the 30-stage bit-per-stage dividers that set the latency,
// then disparity, min/max and test stages. Reset is synchronous and clears
// the valid bits and restores the register defaults. Nothing can stall.
`include "stereo_line_pair_check_unit_assert.svh"
module stereo_line_pair_check_unit
    import slpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_pair_in           i_pair,
    output logic               o_strobe,
    output t_result            o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data
);
    // ---------------- configuration ----------------
    logic [RATIO_W-1:0] r_min_ratio;
    logic [COORD_W-1:0] r_horiz_lim;
    logic [COORD_W-1:0] r_min_disp;
    logic [RATIO_W-1:0] r_ovl_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ratio <= 9'd128;
            r_horiz_lim <= 14'd16;
            r_min_disp  <= 14'd16;
            r_ovl_lim   <= 9'd192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RATIO: r_min_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_HORIZ_LIM: r_horiz_lim <= i_cfg_data;
                CFG_MIN_DISP:  r_min_disp  <= i_cfg_data;
                CFG_OVL_LIM:   r_ovl_lim   <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- s1: capture ----------------
    logic     r_v1;
    t_pair_in r_p1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start & ~busy;
        r_p1 <= i_pair;
    end

    // ---------------- s2: differences and overlap terms ----------------
    logic [COORD_W-1:0] lsy, ley, rsy, rey;
    logic [COORD_W-1:0] sln, eln, spn, epn, lo_top, hi_bot, ext, ov;
    logic signed [COORD_W:0] length;
    logic tall, len_ok;
    assign lsy = r_p1.left_start_y;
    assign ley = r_p1.left_end_y;
    assign rsy = r_p1.right_start_y;
    assign rey = r_p1.right_end_y;

    always_comb begin
        sln    = (lsy < ley) ? lsy : ley;
        eln    = (lsy < ley) ? ley : lsy;
        spn    = (rsy < rey) ? rsy : rey;
        epn    = (rsy < rey) ? rey : rsy;
        ext    = eln - sln;
        tall   = ext > r_horiz_lim;
        length = $signed({1'b0, eln}) - $signed({1'b0, spn});
        len_ok = length > 0;
        lo_top = (sln > spn) ? sln : spn;
        hi_bot = (eln < epn) ? eln : epn;
        // disjoint, enclosing, or partial overlap
        if (epn < sln || spn > eln)      ov = '0;
        else if (epn > eln && spn < sln) ov = eln - sln;
        else                             ov = hi_bot - lo_top;
    end

    logic                       r_v2;
    logic signed [COORD_W:0]    r_dsr, r_dsl, r_der, r_del, r_den;
    logic [COORD_W-1:0]         r_rsx2, r_rex2, r_lsx2, r_lex2, r_ov2, r_len2;
    logic                       r_tall2, r_lenok2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_dsr    <= $signed({1'b0, lsy}) - $signed({1'b0, rey});
        r_dsl    <= $signed({1'b0, rsy}) - $signed({1'b0, lsy});
        r_der    <= $signed({1'b0, ley}) - $signed({1'b0, rey});
        r_del    <= $signed({1'b0, rsy}) - $signed({1'b0, ley});
        r_den    <= $signed({1'b0, rsy}) - $signed({1'b0, rey});
        r_rsx2   <= r_p1.right_start_x;
        r_rex2   <= r_p1.right_end_x;
        r_lsx2   <= r_p1.left_start_x;
        r_lex2   <= r_p1.left_end_x;
        r_ov2    <= ov;
        r_len2   <= length[COORD_W-1:0];
        r_tall2  <= tall;
        r_lenok2 <= len_ok;
    end

    // ---------------- s3: products ----------------
    localparam int PROD_W = 2 * (COORD_W + 1);
    logic                       r_v3;
    logic signed [PROD_W-1:0]   r_pa, r_pb, r_pc, r_pd;
    logic signed [COORD_W:0]    r_den3;
    logic [COORD_W-1:0]         r_lsx3, r_lex3, r_ov3, r_len3;
    logic                       r_tall3, r_lenok3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_pa     <= $signed({1'b0, r_rsx2}) * r_dsr;
        r_pb     <= $signed({1'b0, r_rex2}) * r_dsl;
        r_pc     <= $signed({1'b0, r_rsx2}) * r_der;
        r_pd     <= $signed({1'b0, r_rex2}) * r_del;
        r_den3   <= r_den;
        r_lsx3   <= r_lsx2;
        r_lex3   <= r_lex2;
        r_ov3    <= r_ov2;
        r_len3   <= r_len2;
        r_tall3  <= r_tall2;
        r_lenok3 <= r_lenok2;
    end

    // ---------------- s4: magnitudes, half-divisor bias ----------------
    logic signed [PROD_W:0] ns, ne;
    logic [PROD_W:0]        ans, ane;
    logic [COORD_W-1:0]     ad;
    always_comb begin
        ns  = {r_pa[PROD_W-1], r_pa} + {r_pb[PROD_W-1], r_pb};
        ne  = {r_pc[PROD_W-1], r_pc} + {r_pd[PROD_W-1], r_pd};
        ans = ns[PROD_W] ? -ns : ns;
        ane = ne[PROD_W] ? -ne : ne;
        ad  = r_den3[COORD_W] ? COORD_W'(-r_den3) : r_den3[COORD_W-1:0];
    end

    logic               r_v4;
    logic [DIV_W-1:0]   r_nds, r_nde, r_novl;
    logic [COORD_W-1:0] r_ad4, r_dovl;
    t_side              r_sb4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        // round half away: floor((|n| + floor(|d|/2)) / |d|)
        r_nds  <= ans[DIV_W-1:0] + DIV_W'(ad >> 1);
        r_nde  <= ane[DIV_W-1:0] + DIV_W'(ad >> 1);
        r_ad4  <= ad;
        r_novl <= DIV_W'({r_ov3, 8'd0});
        r_dovl <= r_lenok3 ? r_len3 : COORD_W'(1);
        r_sb4.neg_s  <= ns[PROD_W] ^ r_den3[COORD_W];
        r_sb4.neg_e  <= ne[PROD_W] ^ r_den3[COORD_W];
        r_sb4.zero   <= (r_den3 == 0);
        r_sb4.tall   <= r_tall3;
        r_sb4.len_ok <= r_lenok3;
        r_sb4.lsx    <= r_lsx3;
        r_sb4.lex    <= r_lex3;
    end

    // ---------------- dividers ----------------
    logic             dv_s, dv_e, dv_o;
    logic [DIV_W-1:0] q_s, q_e, q_o;

    slpc_div u_div_s (
        .i_clk, .i_rst_n, .i_valid(r_v4), .i_dividend(r_nds), .i_divisor(r_ad4),
        .o_valid(dv_s), .o_quotient(q_s)
    );
    slpc_div u_div_e (
        .i_clk, .i_rst_n, .i_valid(r_v4), .i_dividend(r_nde), .i_divisor(r_ad4),
        .o_valid(dv_e), .o_quotient(q_e)
    );
    slpc_div u_div_o (
        .i_clk, .i_rst_n, .i_valid(r_v4), .i_dividend(r_novl), .i_divisor(r_dovl),
        .o_valid(dv_o), .o_quotient(q_o)
    );

    // sideband delay line matching the divider depth
    t_side r_sbd [DIV_STAGES];
    always_ff @(posedge i_clk) begin
        r_sbd[0] <= r_sb4;
        for (int i = 1; i < DIV_STAGES; i++) r_sbd[i] <= r_sbd[i-1];
    end
    t_side sb;
    assign sb = r_sbd[DIV_STAGES-1];

    // ---------------- s5: disparities ----------------
    localparam int D_W = DIV_W + 2;
    logic signed [D_W-1:0] ps, pe;
    logic [RATIO_W-1:0]    ovr;
    always_comb begin
        ps = sb.neg_s ? -$signed({2'b00, q_s}) : $signed({2'b00, q_s});
        pe = sb.neg_e ? -$signed({2'b00, q_e}) : $signed({2'b00, q_e});
        if (!sb.tall)        ovr = RATIO_ONE;
        else if (!sb.len_ok) ovr = '0;
        else                 ovr = q_o[RATIO_W-1:0];  // never above one
    end

    logic                  r_v5, r_zero5, r_tall5;
    logic signed [D_W-1:0] r_ds5, r_de5;
    logic [RATIO_W-1:0]    r_ovr5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= dv_s & dv_e & dv_o;
        r_ds5   <= $signed({{(D_W-COORD_W){1'b0}}, sb.lsx}) - ps;
        r_de5   <= $signed({{(D_W-COORD_W){1'b0}}, sb.lex}) - pe;
        r_ovr5  <= ovr;
        r_zero5 <= sb.zero;
        r_tall5 <= sb.tall;
    end

    // ---------------- s6: min / max ----------------
    logic                  r_v6, r_zero6, r_tall6;
    logic signed [D_W-1:0] r_ds6, r_de6, r_mn6, r_mx6;
    logic [RATIO_W-1:0]    r_ovr6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else          r_v6 <= r_v5;
        r_mn6   <= (r_ds5 < r_de5) ? r_ds5 : r_de5;
        r_mx6   <= (r_ds5 < r_de5) ? r_de5 : r_ds5;
        r_ds6   <= r_ds5;
        r_de6   <= r_de5;
        r_ovr6  <= r_ovr5;
        r_zero6 <= r_zero5;
        r_tall6 <= r_tall5;
    end

    // ---------------- s7: tests, saturation, output word ----------------
    localparam int CMP_W = D_W + RATIO_W + 1;
    localparam logic signed [DISP_W-1:0] NEG_ONE = -DISP_W'(1 << FRAC_BITS);
    localparam logic signed [D_W-1:0] SAT_HI = D_W'(32767);
    localparam logic signed [D_W-1:0] SAT_LO = -D_W'(32768);

    logic signed [CMP_W-1:0] lhs, rhs;
    logic                    reject, ok;
    logic signed [D_W-1:0]   min_d;
    logic signed [DISP_W-1:0] sat_s, sat_e;
    always_comb begin
        lhs    = CMP_W'(r_mn6) <<< 8;
        rhs    = $signed({1'b0, r_min_ratio}) * CMP_W'(r_mx6);
        reject = r_zero6 || (r_mx6 <= 0) || (lhs < rhs);
        min_d  = $signed({{(D_W-COORD_W){1'b0}}, r_min_disp});
        ok     = !reject && (r_ds6 >= min_d) && (r_de6 >= min_d) && r_tall6
                 && (r_ovr6 > r_ovl_lim);
        if (r_ds6 > SAT_HI)      sat_s = DISP_W'(SAT_HI);
        else if (r_ds6 < SAT_LO) sat_s = DISP_W'(SAT_LO);
        else                     sat_s = r_ds6[DISP_W-1:0];
        if (r_de6 > SAT_HI)      sat_e = DISP_W'(SAT_HI);
        else if (r_de6 < SAT_LO) sat_e = DISP_W'(SAT_LO);
        else                     sat_e = r_de6[DISP_W-1:0];
    end

    logic    r_v7;
    t_result r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else          r_v7 <= r_v6;
        r_res.accept          <= ok;
        r_res.start_disparity <= reject ? NEG_ONE : sat_s;
        r_res.end_disparity   <= reject ? NEG_ONE : sat_e;
        r_res.overlap_ratio   <= r_ovr6;
    end

    assign o_strobe = r_v7;
    assign o_result = r_res;

    // ---------------- checks ----------------
    `SLPC_ASSERT_SAME(a_ovr_range, o_strobe, o_result.overlap_ratio <= RATIO_ONE)
    `SLPC_ASSERT_SAME(a_acc_disp, o_strobe && o_result.accept, (o_result.start_disparity >= $signed({2'b00, r_min_disp})) && (o_result.end_disparity >= $signed({2'b00, r_min_disp})))
    `SLPC_ASSERT_SAME(a_acc_ovl, o_strobe && o_result.accept, o_result.overlap_ratio > r_ovl_lim)
    `SLPC_ASSERT_NEXT(a_div_to_s5, dv_s, r_v5 && (dv_e == dv_s) && (dv_o == dv_s))
endmodule
